// File: rtl/anchor_box_decode_threshold_defines.svh
// Assertion helpers for the anchor box decoder.
`ifndef ANCHOR_BOX_DECODE_THRESHOLD_DEFINES_SVH
`define ANCHOR_BOX_DECODE_THRESHOLD_DEFINES_SVH

// Condition must never hold outside reset.
`define ABD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("abd: forbidden condition seen");

// Antecedent in one cycle implies consequent in the next.
`define ABD_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("abd: expected follow-up missing");

`endif

// File: rtl/abd_pkg.sv
package abd_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR = $clog2(QDEPTH);
  localparam int ODEPTH = 4;
  localparam int OPTR = $clog2(ODEPTH);

  typedef enum logic [2:0] {
    REG_ANCHOR_SIZES = 3'd0,
    REG_STRIDE_SHIFT = 3'd1,
    REG_GRID_WIDTH   = 3'd2,
    REG_CLASS_COUNT  = 3'd3,
    REG_OBJ_THRES    = 3'd4,
    REG_SCORE_THRES  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [59:0]        anchor_sizes;
    logic [2:0]         stride_shift;
    logic [9:0]         grid_width;
    logic [7:0]         class_count;
    logic signed [15:0] obj_logit_thres;
    logic [15:0]        score_thres;
  } cfg_t;

  typedef enum logic [2:0] {
    K_CX  = 3'd0,
    K_CY  = 3'd1,
    K_W   = 3'd2,
    K_H   = 3'd3,
    K_OBJ = 3'd4,
    K_CLS = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] sig;
    logic [8:0]  coord;
    logic [9:0]  anchor;
    logic        pass;
    logic [7:0]  label;
  } item_t;

  typedef struct packed {
    logic signed [16:0] center_x;
    logic signed [16:0] center_y;
    logic [15:0]        box_w;
    logic [15:0]        box_h;
    logic [15:0]        score;
    logic [7:0]         class_label;
  } result_t;

  typedef struct packed {
    logic [OPTR:0] occupancy;
    logic          result_push;
    logic          out_full;
  } back_status_t;

endpackage

// File: rtl/abd_front.sv
module abd_front (
  input  logic                clk,
  input  logic                rst,
  input  abd_pkg::cfg_t       cfg,
  input  logic                accept,
  input  logic signed [15:0]  logit,
  input  logic                tensor_start,
  output logic                item_valid,
  output abd_pkg::item_t      item
);
  import abd_pkg::*;

  localparam logic [16:0] KNOTS [17] = '{
    17'd32768, 17'd40793, 17'd47911, 17'd53581, 17'd57724, 17'd60565,
    17'd62428, 17'd63615, 17'd64357, 17'd64816, 17'd65097, 17'd65269,
    17'd65374, 17'd65438, 17'd65476, 17'd65500, 17'd65514
  };

  logic [8:0] channel_count, cell_x, cell_y;
  logic [1:0] anchor_count;
  logic [8:0] chan, cx, cy;
  logic [1:0] anc;
  logic [8:0] last;
  logic [16:0] mag, kl, kh, interp;
  logic [19:0] prod;
  logic [16:0] sig_pos;
  logic [4:0]  pos;

  always_comb begin
    chan = tensor_start ? 9'd0 : channel_count;
    anc  = tensor_start ? 2'd0 : anchor_count;
    cx   = tensor_start ? 9'd0 : cell_x;
    cy   = tensor_start ? 9'd0 : cell_y;
    last = {1'b0, cfg.class_count} + 9'd4;

    // table sigmoid on |x|, mirror for negative logits
    mag = logit[15] ? 17'(-$signed({logit[15], logit})) : {1'b0, logit};
    kl = KNOTS[mag[10:7]];
    kh = KNOTS[5'(mag[10:7]) + 5'd1];
    prod = 20'((kh - kl) * mag[6:0]);
    interp = kl + 17'(prod >> 7);
    sig_pos = (mag >= 17'd2048) ? KNOTS[16] : interp;

    item.sig    = logit[15] ? 16'(17'd65536 - sig_pos) : sig_pos[15:0];
    item.coord  = (chan == 9'd1) ? cy : cx;
    item.pass   = logit > cfg.obj_logit_thres;
    item.label  = 8'(chan - 9'd5);
    pos = 5'(anc) * 5'd2 + ((chan == 9'd3) ? 5'd1 : 5'd0);
    item.anchor = cfg.anchor_sizes[10*pos +: 10];

    item_valid = accept;
    unique case (chan)
      9'd0:    item.kind = K_CX;
      9'd1:    item.kind = K_CY;
      9'd2:    item.kind = K_W;
      9'd3:    item.kind = K_H;
      9'd4:    item.kind = K_OBJ;
      default: begin
        item.kind = K_CLS;
        if (chan > last) item_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= '0;
      anchor_count  <= '0;
      cell_x        <= '0;
      cell_y        <= '0;
    end else if (accept) begin
      if (chan >= last) begin
        channel_count <= '0;
        if (anc >= 2'd2) begin
          anchor_count <= '0;
          if ({1'b0, cx} + 10'd1 >= cfg.grid_width || cx >= 9'd511) begin
            cell_x <= '0;
            cell_y <= cy + 9'd1;
          end else begin
            cell_x <= cx + 9'd1;
            cell_y <= cy;
          end
        end else begin
          anchor_count <= anc + 2'd1;
          cell_x <= cx;
          cell_y <= cy;
        end
      end else begin
        channel_count <= chan + 9'd1;
        anchor_count  <= anc;
        cell_x        <= cx;
        cell_y        <= cy;
      end
    end
  end
endmodule

// File: rtl/abd_queue.sv
module abd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  abd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output abd_pkg::item_t head
);
  import abd_pkg::*;

  item_t           slots [QDEPTH];
  logic [QPTR-1:0] wr_ptr, rd_ptr;
  logic [QPTR:0]   count;

  assign full  = count == (QPTR+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR+1)'(push) - (QPTR+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end
endmodule

// File: rtl/abd_back.sv
module abd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  abd_pkg::cfg_t        cfg,
  input  logic                 q_empty,
  input  abd_pkg::item_t       q_head,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output abd_pkg::result_t     result,
  output abd_pkg::back_status_t status
);
  import abd_pkg::*;

  // stage 1 register
  logic               s1_valid;
  kind_t              s1_kind;
  logic signed [16:0] s1_center;
  logic [33:0]        s1_sq;
  logic [9:0]         s1_anchor;
  logic [15:0]        s1_score;
  logic               s1_pass;
  logic [7:0]         s1_label;

  logic signed [16:0] held_center_x, held_center_y;
  logic [15:0]        held_width, held_height, object_conf;
  logic               object_pass;

  result_t            oslots [ODEPTH];
  logic [OPTR-1:0]    owr, ord;
  logic [OPTR:0]      ocount;

  logic signed [27:0] t;
  logic signed [34:0] ts;
  logic signed [22:0] r;
  logic signed [16:0] center;
  logic [16:0]        sx;
  logic [43:0]        size_prod;
  logic               res_push, out_pop;
  result_t            res;

  assign q_pop = !q_empty && ({1'b0, ocount} + (OPTR+2)'(s1_valid) < (OPTR+2)'(ODEPTH));

  always_comb begin
    t  = $signed({11'd0, q_head.sig, 1'b0}) - 28'sd32768
       + $signed({3'd0, q_head.coord, 16'd0});
    ts = 35'(t) <<< cfg.stride_shift;
    r  = 23'(ts >>> 12);
    if (r > 23'sd65535)       center = 17'sd65535;
    else if (r < -23'sd65536) center = -17'sd65536;
    else                      center = r[16:0];
    sx = {q_head.sig, 1'b0};
    size_prod = s1_sq * s1_anchor;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= q_pop;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_kind   <= q_head.kind;
      s1_center <= center;
      s1_sq     <= sx * sx;
      s1_anchor <= q_head.anchor;
      s1_score  <= 16'((32'(object_conf) * 32'(q_head.sig)) >> 16);
      s1_pass   <= object_pass;
      s1_label  <= q_head.label;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_conf <= '0;
      object_pass <= 1'b0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_width    <= '0;
      held_height   <= '0;
    end else begin
      if (q_pop && q_head.kind == K_OBJ) begin
        object_conf <= q_head.sig;
        object_pass <= q_head.pass;
      end
      if (s1_valid) begin
        unique case (s1_kind)
          K_CX:    held_center_x <= s1_center;
          K_CY:    held_center_y <= s1_center;
          K_W:     held_width    <= size_prod[43:28];
          K_H:     held_height   <= size_prod[43:28];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res.center_x    = held_center_x;
    res.center_y    = held_center_y;
    res.box_w       = held_width;
    res.box_h       = held_height;
    res.score       = s1_score;
    res.class_label = s1_label;
    res_push = s1_valid && s1_kind == K_CLS && s1_pass && s1_score > cfg.score_thres;
  end

  assign empty   = ocount == '0;
  assign out_pop = pop && !empty;
  assign result  = oslots[ord];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr <= '0;
      ord <= '0;
      ocount <= '0;
    end else begin
      if (res_push) owr <= owr + 1'b1;
      if (out_pop)  ord <= ord + 1'b1;
      ocount <= ocount + (OPTR+1)'(res_push) - (OPTR+1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) oslots[owr] <= res;
  end

  assign status.occupancy   = ocount;
  assign status.result_push = res_push;
  assign status.out_full    = ocount == (OPTR+1)'(ODEPTH);
endmodule

// File: rtl/anchor_box_decode_threshold.sv
// Anchor box decoder with objectness and score gating, one detection layer.
// Input channel: push/full. One logit word per accepted push, in tensor memory
// order (cell, anchor, channel); tensor_start marks the first word of a tensor.
// Result channel: empty/pop. Each class that passes the objectness and score
// gates yields one word with the held box, score and class label, oldest first.
// Configuration: wr_en/wr_index/wr_data, to be written by the user only while
// the block is idle; the block itself does not enforce this. A front stage
// counts channels, takes the sigmoid from a knot table and classifies the
// word; a four-word queue decouples it from the back pipeline, which decodes
// centers and sizes, gates objectness and scores, and fills a four-word
// result queue. One logit word per cycle is sustained while full stays low; a
// result passes the middle queue, the stage 1 multiply register and the result
// queue write before it shows on the result ports.
// Reset clears all counters, queues and held box state and reloads the
// register defaults. When pop stays low the result queue fills, the back
// pipeline stops drawing from the middle queue, and full rises once that
// queue is full too; no word is dropped.
module anchor_box_decode_threshold (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] logit,
  input  logic               tensor_start,
  output logic               empty,
  input  logic               pop,
  output logic signed [16:0] center_x,
  output logic signed [16:0] center_y,
  output logic [15:0]        box_w,
  output logic [15:0]        box_h,
  output logic [15:0]        score,
  output logic [7:0]         class_label,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [59:0]        wr_data
);
  import abd_pkg::*;
`include "anchor_box_decode_threshold_defines.svh"

  cfg_t         cfg;
  logic         accept, item_valid, q_pop, q_empty;
  item_t        item, q_head;
  result_t      result;
  back_status_t status;

  // hold configuration registers; load defaults at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.anchor_sizes    <= 60'd25932013970142218;
      cfg.stride_shift    <= 3'd3;
      cfg.grid_width      <= 10'd80;
      cfg.class_count     <= 8'd80;
      cfg.obj_logit_thres <= -16'sd281;
      cfg.score_thres     <= 16'd16384;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ANCHOR_SIZES: cfg.anchor_sizes    <= wr_data;
        REG_STRIDE_SHIFT: cfg.stride_shift    <= wr_data[2:0];
        REG_GRID_WIDTH:   cfg.grid_width      <= wr_data[9:0];
        REG_CLASS_COUNT:  cfg.class_count     <= wr_data[7:0];
        REG_OBJ_THRES:    cfg.obj_logit_thres <= wr_data[15:0];
        REG_SCORE_THRES:  cfg.score_thres     <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  abd_front u_front (
    .clk, .rst, .cfg, .accept, .logit, .tensor_start,
    .item_valid, .item
  );

  abd_queue u_queue (
    .clk, .rst,
    .push(item_valid), .push_item(item), .full,
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  abd_back u_back (
    .clk, .rst, .cfg, .q_empty, .q_head, .q_pop,
    .pop, .empty, .result, .status
  );

  assign center_x    = result.center_x;
  assign center_y    = result.center_y;
  assign box_w       = result.box_w;
  assign box_h       = result.box_h;
  assign score       = result.score;
  assign class_label = result.class_label;

  // the credit check must keep the result queue from overflowing
  `ABD_NEVER(a_no_result_overflow, status.result_push && status.out_full && !pop)
  `ABD_NEVER(a_occupancy_bound, status.occupancy > (OPTR+1)'(ODEPTH))
  `ABD_NEXT(a_push_shows_result, status.result_push, !empty)
endmodule

// File: tb/anchor_box_decode_threshold_test.sv
module anchor_box_decode_threshold_test;
  timeunit 1ns;
  timeprecision 1ps;
  import abd_pkg::*;

  localparam int LIMIT = 600000;
  localparam int ANCHORS = 3;

  // Q0.16 sigmoid knots at 0, 0.5, ... 8.0
  localparam int KNOT [17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
    64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic signed [15:0] logit = '0;
  logic tensor_start = 0;
  logic empty;
  logic pop = 0;
  logic signed [16:0] center_x, center_y;
  logic [15:0] box_w, box_h, score;
  logic [7:0] class_label;
  logic wr_en = 0;
  logic [2:0] wr_index = REG_ANCHOR_SIZES;
  logic [59:0] wr_data = '0;

  anchor_box_decode_threshold dut (.*);

  always #5 clk = ~clk;

  // Mirror of the register file
  logic [59:0] m_anchor_pairs;
  logic [2:0] m_stride;
  logic [9:0] m_grid;
  logic [7:0] m_classes;
  logic signed [15:0] m_obj_thres;
  logic [15:0] m_score_thres;

  // Mirror of the decode state
  logic [8:0] chan, cx, cy;
  logic [1:0] anc;
  logic signed [16:0] hold_cx, hold_cy;
  logic [15:0] hold_w, hold_h, obj_conf;
  logic obj_pass;

  // Words waiting to be pushed, and decoded boxes waiting to be popped
  logic signed [15:0] pend_logit[$];
  logic pend_start[$];
  result_t box_expect[$];

  int errors = 0;
  int cyc = 0;
  int sent_total = 0;
  bit no_gaps = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit stalled_once = 0;

  function automatic int sigmoid_q16(int x);
    int a, v, i, f;
    a = (x < 0) ? -x : x;
    if (a >= 2048) v = KNOT[16];
    else begin
      i = a >> 7;
      f = a & 127;
      v = KNOT[i] + (((KNOT[i+1] - KNOT[i]) * f) >> 7);
    end
    return (x < 0) ? 65536 - v : v;
  endfunction

  function automatic logic signed [16:0] center_px(int s, int coord);
    longint t;
    t = longint'(s) * 2 - 32768 + longint'(coord) * 65536;
    t = t * (longint'(1) << m_stride);
    t = t >>> 12;  // arithmetic shift floors
    if (t > 65535) t = 65535;
    if (t < -65536) t = -65536;
    return t[16:0];
  endfunction

  function automatic logic [15:0] size_px(int s, int anchor_px);
    longint unsigned sx, r;
    sx = longint'(s) * 2;
    r = (sx * sx * anchor_px) >> 28;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic int anchor_px(int a, int which);
    return (m_anchor_pairs >> (a * 20 + which * 10)) & 10'h3FF;
  endfunction

  // Advance the decoder mirror by one accepted logit word
  task automatic decode_word(logic signed [15:0] x, logic first);
    int s, sc;
    logic [8:0] last;
    result_t r;
    last = m_classes + 9'd4;
    if (first) begin
      chan = 0; anc = 0; cx = 0; cy = 0;
    end
    s = sigmoid_q16(int'(x));
    if (chan == 0) hold_cx = center_px(s, cx);
    else if (chan == 1) hold_cy = center_px(s, cy);
    else if (chan == 2) hold_w = size_px(s, anchor_px(anc, 0));
    else if (chan == 3) hold_h = size_px(s, anchor_px(anc, 1));
    else if (chan == 4) begin
      obj_pass = x > m_obj_thres;
      obj_conf = s[15:0];
    end else if (chan <= last && obj_pass) begin
      sc = int'((longint'(obj_conf) * s) >>> 16);
      if (sc > 65535) sc = 65535;
      if (sc > m_score_thres) begin
        r.center_x = hold_cx;
        r.center_y = hold_cy;
        r.box_w = hold_w;
        r.box_h = hold_h;
        r.score = sc[15:0];
        r.class_label = 8'(chan - 9'd5);
        box_expect.insert(box_expect.size(), r);
      end
    end
    if (chan >= last) begin
      chan = 0;
      if (anc + 1 >= ANCHORS) begin
        anc = 0;
        if (cx + 1 >= m_grid || cx >= 511) begin
          cx = 0;
          cy = cy + 9'd1;
        end else cx = cx + 9'd1;
      end else anc = anc + 2'd1;
    end else chan = chan + 9'd1;
  endtask

  function automatic int pick_gap();
    if (no_gaps || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 24) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 3);
  endfunction

  // Driver: predict on acceptance, then hold, idle or offer the next word
  always @(posedge clk) begin
    if (rst) begin
      push <= 0;
    end else begin
      if (push && !full) decode_word(logit, tensor_start);
      if (push && full) begin
        // hold the offered word
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 0;
      end else if (pend_logit.size() > 0) begin
        push <= 1;
        logit <= pend_logit.pop_front();
        tensor_start <= pend_start.pop_front();
        send_gap = pick_gap();
      end else begin
        push <= 0;
      end
    end
  end

  // Monitor: check each popped word against the oldest decoded box
  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (box_expect.size() == 0) begin
          $display("%0t: unexpected word cx=%0d cy=%0d w=%0d h=%0d score=%0d label=%0d",
                   $time, center_x, center_y, box_w, box_h, score, class_label);
          errors++;
        end else begin
          e = box_expect.pop_front();
          if (center_x !== e.center_x) begin
            $display("%0t: center_x expected %0d got %0d", $time, e.center_x, center_x);
            errors++;
          end
          if (center_y !== e.center_y) begin
            $display("%0t: center_y expected %0d got %0d", $time, e.center_y, center_y);
            errors++;
          end
          if (box_w !== e.box_w) begin
            $display("%0t: box_w expected %0d got %0d", $time, e.box_w, box_w);
            errors++;
          end
          if (box_h !== e.box_h) begin
            $display("%0t: box_h expected %0d got %0d", $time, e.box_h, box_h);
            errors++;
          end
          if (score !== e.score) begin
            $display("%0t: score expected %0d got %0d", $time, e.score, score);
            errors++;
          end
          if (class_label !== e.class_label) begin
            $display("%0t: class_label expected %0d got %0d", $time, e.class_label,
                     class_label);
            errors++;
          end
        end
      end
      // Long hold-off once the sender has a deep backlog, so full must rise
      if (!stalled_once && pend_logit.size() > 150) begin
        stalled_once = 1;
        stall_left = 400;
      end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 299) == 0) begin
        stall_left = $urandom_range(20, 80);
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 0;
      end else begin
        pop <= no_gaps ? 1'b1 : ($urandom_range(0, 9) < 7);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc++;
    if (cyc > LIMIT) begin
      $display("anchor_box_decode_threshold_test: errors");
      $finish;
    end
  end

  task automatic set_reg(reg_index_t idx, logic [59:0] v);
    @(posedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= v;
    case (idx)
      REG_ANCHOR_SIZES: m_anchor_pairs = v;
      REG_STRIDE_SHIFT: m_stride = v[2:0];
      REG_GRID_WIDTH:   m_grid = v[9:0];
      REG_CLASS_COUNT:  m_classes = v[7:0];
      REG_OBJ_THRES:    m_obj_thres = v[15:0];
      REG_SCORE_THRES:  m_score_thres = v[15:0];
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 0;
  endtask

  // Pause the sender until every decoded box has been popped and the pipe is drained
  task automatic drain();
    while (pend_logit.size() > 0 || push || box_expect.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    #1;
  endtask

  function automatic logic signed [15:0] rand_logit();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 16'sh7FFF;
    if (k == 1) return -16'sh8000;
    if (k == 2) return 16'($urandom());
    if (k < 6) return 16'($urandom_range(0, 2560));  // strong positive
    return 16'($urandom_range(0, 5120) - 2560);
  endfunction

  task automatic add_word(logic signed [15:0] x, logic first);
    pend_logit.insert(pend_logit.size(), x);
    pend_start.insert(pend_start.size(), first);
    sent_total++;
  endtask

  // Queue one tensor of ncells cells; drop the tail now and then
  task automatic add_tensor(int ncells);
    int total, n;
    total = ncells * ANCHORS * (m_classes + 5);
    if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
    for (n = 0; n < total; n++)
      add_word(rand_logit(), n == 0 || $urandom_range(0, 499) == 0);
  endtask

  task automatic rand_regs();
    set_reg(REG_ANCHOR_SIZES, 60'({$urandom(), $urandom()}));
    set_reg(REG_STRIDE_SHIFT, 60'($urandom_range(0, 7)));
    set_reg(REG_GRID_WIDTH, 60'($urandom_range(0, 9) == 0 ? $urandom()
                                                          : $urandom_range(1, 5)));
    set_reg(REG_CLASS_COUNT, 60'($urandom_range(0, 19) == 0 ? $urandom_range(0, 255)
                                                            : $urandom_range(1, 6)));
    set_reg(REG_OBJ_THRES, 60'($urandom_range(0, 5) == 0 ? $urandom()
                                                         : $urandom_range(0, 1024) - 512));
    set_reg(REG_SCORE_THRES, 60'($urandom_range(0, 5) == 0 ? $urandom()
                                                           : $urandom_range(0, 50000)));
  endtask

  initial begin
    int phase, a;
    m_anchor_pairs = 60'd25932013970142218;
    m_stride = 3;
    m_grid = 80;
    m_classes = 80;
    m_obj_thres = -281;
    m_score_thres = 16384;
    chan = 0; anc = 0; cx = 0; cy = 0;
    hold_cx = 0; hold_cy = 0; hold_w = 0; hold_h = 0;
    obj_conf = 0; obj_pass = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // Directed: one class, extremes of every box channel, thresholds at the edge
    set_reg(REG_CLASS_COUNT, 1);
    set_reg(REG_GRID_WIDTH, 2);
    set_reg(REG_SCORE_THRES, 0);
    #1;
    add_word(16'sh7FFF, 1); add_word(-16'sh8000, 0); add_word(16'sh7FFF, 0);
    add_word(-16'sh8000, 0); add_word(16'sh7FFF, 0); add_word(16'sh7FFF, 0);
    add_word(0, 0); add_word(0, 0); add_word(0, 0); add_word(0, 0);
    add_word(-16'sd281, 0); add_word(16'sh7FFF, 0);  // at threshold: gated off
    add_word(-16'sh8000, 0); add_word(16'sh7FFF, 0); add_word(-16'sh8000, 0);
    add_word(16'sh7FFF, 0); add_word(-16'sd280, 0); add_word(-16'sh8000, 0);
    drain();
    // Zero classes and extreme stride and grid
    set_reg(REG_CLASS_COUNT, 0);
    set_reg(REG_STRIDE_SHIFT, 7);
    set_reg(REG_GRID_WIDTH, 0);
    #1;
    for (a = 0; a < 6; a++) add_word(rand_logit(), a == 0);
    drain();
    set_reg(REG_CLASS_COUNT, 2);
    set_reg(REG_STRIDE_SHIFT, 0);
    set_reg(REG_ANCHOR_SIZES, 60'hFFF_FFFF_FFFF_FFFF);
    set_reg(REG_OBJ_THRES, 16'h8000);
    #1;
    add_tensor(1);
    drain();

    // Random phases, some at register extremes, some with no idling
    phase = 0;
    while (phase < 12 || sent_total < 1800) begin
      rand_regs();
      case (phase % 8)
        1: set_reg(REG_GRID_WIDTH, 512);
        2: set_reg(REG_GRID_WIDTH, 10'h3FF);
        3: set_reg(REG_SCORE_THRES, 16'hFFFF);
        4: set_reg(REG_OBJ_THRES, 16'h7FFF);
        5: set_reg(REG_ANCHOR_SIZES, 60'h0);
        default: ;
      endcase
      if (phase == 0) begin
        set_reg(REG_CLASS_COUNT, 4);
        set_reg(REG_OBJ_THRES, 16'hFE00);
        set_reg(REG_SCORE_THRES, 0);
      end
      no_gaps = (phase % 5 == 2);
      #1;
      add_tensor(m_classes > 20 ? 1 : $urandom_range(1, 4));
      // deep backlog of a full eight-cell tensor so the long hold-off fills the block
      if (phase == 0) begin
        for (a = 0; a < 8 * ANCHORS * (m_classes + 5); a++)
          add_word(rand_logit(), a == 0);
      end
      drain();
      phase++;
    end
    no_gaps = 0;
    drain();
    if (errors == 0) $display("anchor_box_decode_threshold_test: clean");
    else $display("anchor_box_decode_threshold_test: errors");
    $finish;
  end
endmodule
